// ===== rtl/core/eeu_pkg.sv =====
// shared types and entity tables for the xml entity escape/unescape block
// no dependencies
package eeu_pkg;

	localparam int NUM_ENT     = 5;
	localparam int HOLD_DEPTH  = 5;
	localparam int MAX_OUT     = 6;
	localparam int CNT_W       = 3;
	localparam int QUEUE_DEPTH = 2;

	localparam logic [7:0] AMP = 8'h26;

	// one entry per entity: replaced byte, text length, entity text
	localparam logic [7:0] ENT_BYTE [NUM_ENT] = '{8'h26, 8'h3C, 8'h3E, 8'h27, 8'h22};
	localparam logic [CNT_W-1:0] ENT_LEN [NUM_ENT] = '{3'd5, 3'd4, 3'd4, 3'd6, 3'd6};
	localparam logic [7:0] ENT_TEXT [NUM_ENT][MAX_OUT] = '{
		'{8'h26, 8'h61, 8'h6D, 8'h70, 8'h3B, 8'h00},
		'{8'h26, 8'h6C, 8'h74, 8'h3B, 8'h00, 8'h00},
		'{8'h26, 8'h67, 8'h74, 8'h3B, 8'h00, 8'h00},
		'{8'h26, 8'h61, 8'h70, 8'h6F, 8'h73, 8'h3B},
		'{8'h26, 8'h71, 8'h75, 8'h6F, 8'h74, 8'h3B}
	};

	// bytes one accepted item produces, in output order
	typedef struct packed {
		logic [MAX_OUT-1:0][7:0] bytes;
		logic [CNT_W-1:0]        cnt;
		logic                    last;
	} job_t;

endpackage

// ===== rtl/core/xml_entity_escape_unescape_top.sv =====
// top level of the xml predefined entity escape/unescape block
// depends on eeu_pkg, eeu_front, eeu_queue, eeu_back
//
// Input side is a queue write port: push a text byte with end_of_text while
// full is low. Output side is a queue read port: out_byte/out_last are valid
// while empty is low, pop takes the word. decode_mode is written through cfg_valid
// (cfg_ready is always high); the user must write it only while the block is
// idle, which the block does not enforce. A write drops any held entity prefix.
// In escape mode a special byte becomes a 4 to 6 byte entity; in decode mode
// the five predefined entities collapse to one byte in a single pass, and a
// partial entity is held until it matches, fails or the text ends.
// An accepted byte's job goes into the job queue; the back end moves its words
// from the queue head into the output register, one word per cycle while pop
// keeps that register free, so throughput is one byte per cycle when each
// byte yields one word. A multi-word item holds the queue head until its last
// word, and full rises once the job queue (QUEUE_DEPTH jobs) backs up.
// When pop stays low the output register holds, the queue fills and full
// goes high. Reset clears the mode to escape, the held prefix and the job queue.
module xml_entity_escape_unescape_top #(
	parameter int QUEUE_DEPTH = eeu_pkg::QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_valid,
	output logic       cfg_ready,
	input  logic       decode_mode,
	input  logic       push,
	output logic       full,
	input  logic [7:0] text_byte,
	input  logic       end_of_text,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_byte,
	output logic       out_last
);

	eeu_pkg::job_t new_job;
	eeu_pkg::job_t head_job;
	logic          job_push;
	logic          job_pop;
	logic          head_valid;
	logic          accept;

	assign cfg_ready = 1'b1;
	assign accept    = push && !full;

	eeu_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr      (cfg_valid),
		.cfg_mode    (decode_mode),
		.accept      (accept),
		.text_byte   (text_byte),
		.end_of_text (end_of_text),
		.job         (new_job),
		.job_push    (job_push)
	);

	eeu_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (job_push),
		.push_job   (new_job),
		.pop        (job_pop),
		.head       (head_job),
		.head_valid (head_valid),
		.full       (full)
	);

	eeu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head_job),
		.head_valid (head_valid),
		.job_pop    (job_pop),
		.out_byte   (out_byte),
		.out_last   (out_last),
		.empty      (empty),
		.pop        (pop)
	);

endmodule

// ===== rtl/core/eeu_front.sv =====
// front end: mode register, held entity prefix, classifies each text byte into a job
// depends on eeu_pkg
module eeu_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             cfg_wr,
	input  logic             cfg_mode,
	input  logic             accept,
	input  logic [7:0]       text_byte,
	input  logic             end_of_text,
	output eeu_pkg::job_t    job,
	output logic             job_push
);

	localparam int CNT_W = eeu_pkg::CNT_W;

	logic                        mode_q;
	logic [eeu_pkg::CNT_W-1:0]   held_cnt_q;
	logic [7:0]                  held_q [eeu_pkg::HOLD_DEPTH];

	logic [7:0]                  cand [eeu_pkg::MAX_OUT];
	logic [eeu_pkg::CNT_W:0]     len;
	logic [eeu_pkg::NUM_ENT-1:0] ent_ok;
	logic                        any_full;
	logic                        any_partial;
	logic [7:0]                  full_byte;
	logic                        esc_hit;
	logic [eeu_pkg::CNT_W-1:0]   esc_idx;
	logic                        is_amp;

	assign len    = {1'b0, held_cnt_q} + 4'd1;
	assign is_amp = (text_byte == eeu_pkg::AMP);

	// candidate prefix: held bytes followed by the new byte
	always_comb begin
		for (int i = 0; i < eeu_pkg::HOLD_DEPTH; i++) begin
			cand[i] = (CNT_W'(i) < held_cnt_q) ? held_q[i] : text_byte;
		end
		cand[eeu_pkg::MAX_OUT-1] = text_byte;
	end

	always_comb begin
		any_full    = 1'b0;
		any_partial = 1'b0;
		full_byte   = text_byte;
		for (int e = 0; e < eeu_pkg::NUM_ENT; e++) begin
			ent_ok[e] = (len <= {1'b0, eeu_pkg::ENT_LEN[e]});
			for (int i = 0; i < eeu_pkg::MAX_OUT; i++) begin
				if (CNT_W'(i) <= held_cnt_q && cand[i] != eeu_pkg::ENT_TEXT[e][i])
					ent_ok[e] = 1'b0;
			end
			if (ent_ok[e]) begin
				if (len == {1'b0, eeu_pkg::ENT_LEN[e]}) begin
					any_full  = 1'b1;
					full_byte = eeu_pkg::ENT_BYTE[e];
				end else begin
					any_partial = 1'b1;
				end
			end
		end
	end

	always_comb begin
		esc_hit = 1'b0;
		esc_idx = '0;
		for (int e = 0; e < eeu_pkg::NUM_ENT; e++) begin
			if (text_byte == eeu_pkg::ENT_BYTE[e]) begin
				esc_hit = 1'b1;
				esc_idx = CNT_W'(e);
			end
		end
	end

	always_comb begin
		for (int i = 0; i < eeu_pkg::MAX_OUT; i++) begin
			job.bytes[i] = cand[i];
		end
		job.last = end_of_text;
		job.cnt  = '0;
		if (!mode_q) begin
			if (esc_hit) begin
				for (int i = 0; i < eeu_pkg::MAX_OUT; i++) begin
					job.bytes[i] = eeu_pkg::ENT_TEXT[esc_idx][i];
				end
				job.cnt = eeu_pkg::ENT_LEN[esc_idx];
			end else begin
				job.bytes[0] = text_byte;
				job.cnt      = CNT_W'(1);
			end
		end else if (any_full) begin
			job.bytes[0] = full_byte;
			job.cnt      = CNT_W'(1);
		end else if (any_partial) begin
			job.cnt = end_of_text ? len[CNT_W-1:0] : '0;
		end else begin
			// failed match: held bytes go out, a new ampersand starts a fresh prefix
			job.cnt = (!is_amp || end_of_text) ? len[CNT_W-1:0] : held_cnt_q;
		end
	end

	assign job_push = accept && (job.cnt != '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q     <= 1'b0;
			held_cnt_q <= '0;
		end else if (cfg_wr) begin
			mode_q     <= cfg_mode;
			held_cnt_q <= '0;
		end else if (accept) begin
			if (!mode_q || any_full || end_of_text)
				held_cnt_q <= '0;
			else if (any_partial)
				held_cnt_q <= len[CNT_W-1:0];
			else
				held_cnt_q <= is_amp ? CNT_W'(1) : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			if (mode_q && !any_full && !any_partial) begin
				held_q[0] <= text_byte;
			end else begin
				for (int i = 0; i < eeu_pkg::HOLD_DEPTH; i++) begin
					held_q[i] <= cand[i];
				end
			end
		end
	end

endmodule

// ===== rtl/core/eeu_queue.sv =====
// short job queue between front and back ends
// depends on eeu_pkg
module eeu_queue #(
	parameter int DEPTH = eeu_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  eeu_pkg::job_t push_job,
	input  logic          pop,
	output eeu_pkg::job_t head,
	output logic          head_valid,
	output logic          full
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	eeu_pkg::job_t mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign head       = mem_q[rd_ptr_q];
	assign head_valid = (count_q != '0);
	assign full       = (count_q == CW'(DEPTH));

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

endmodule

// ===== rtl/core/eeu_back.sv =====
// back end: walks the bytes of the head job into the output register
// depends on eeu_pkg
module eeu_back (
	input  logic          clk,
	input  logic          arst_n,
	input  eeu_pkg::job_t head,
	input  logic          head_valid,
	output logic          job_pop,
	output logic [7:0]    out_byte,
	output logic          out_last,
	output logic          empty,
	input  logic          pop
);

	logic [eeu_pkg::CNT_W-1:0] idx_q;
	logic                      out_valid_q;
	logic [7:0]                out_byte_q;
	logic                      out_last_q;
	logic                      slot;
	logic                      take;
	logic                      at_end;

	assign slot    = !out_valid_q || pop;
	assign take    = slot && head_valid;
	assign at_end  = (idx_q == head.cnt - 1'b1);
	assign job_pop = take && at_end;

	assign out_byte = out_byte_q;
	assign out_last = out_last_q;
	assign empty    = !out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (slot)
				out_valid_q <= head_valid;
			if (take)
				idx_q <= at_end ? '0 : idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_byte_q <= head.bytes[idx_q];
			out_last_q <= head.last && at_end;
		end
	end

endmodule

// ===== rtl/core/eeu_checker.sv =====
// port-level checks for the xml entity escape/unescape top level
// depends on xml_entity_escape_unescape_top (bound below)
module eeu_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       cfg_ready,
	input logic       push,
	input logic       full,
	input logic       empty,
	input logic       pop,
	input logic [7:0] out_byte,
	input logic       out_last
);

	// a waiting word is not replaced until it is taken
	a_hold_word: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(out_byte) && $stable(out_last)))
		else $error("output word changed while stalled");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("config channel not ready");

	// the queue only fills on an accepted byte
	a_full_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(full) |-> $past(push && !full))
		else $error("full rose without an accepted byte");

	// the output only drains on a pop
	a_empty_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(empty) |-> $past(pop))
		else $error("output emptied without a pop");

endmodule

bind xml_entity_escape_unescape_top eeu_checker u_eeu_checker (.*);

// ===== tb/xml_entity_escape_unescape_top_tb.sv =====
// testbench for xml_entity_escape_unescape_top: queue-style push/pop traffic with
// bursty input, stalling output and mode switches, checked against an in-bench model
// depends on the rtl under rtl/core (eeu_pkg and the top level)
`timescale 1ns / 1ps

module xml_entity_escape_unescape_top_tb;

	localparam int CYCLE_LIMIT = 200000;
	localparam int NUM_ENT = 5;
	localparam logic MODE_ESCAPE = 1'b0;
	localparam logic MODE_DECODE = 1'b1;
	localparam logic [7:0] CH_AMP = "&";
	localparam logic [7:0] CH_HASH = "#";
	localparam logic [7:0] CH_SEMI = ";";

	typedef struct {
		logic [7:0] ch;
		logic       eot;
	} text_item_t;

	typedef struct {
		logic [7:0] data;
		logic       last;
	} conv_word_t;

	logic       clk;
	logic       arst_n = 1'b0;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic       decode_mode = 1'b0;
	logic       push = 1'b0;
	logic       full;
	logic [7:0] text_byte = 8'h00;
	logic       end_of_text = 1'b0;
	logic       empty;
	logic       pop = 1'b0;
	logic [7:0] out_byte;
	logic       out_last;

	xml_entity_escape_unescape_top uut (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.decode_mode (decode_mode),
		.push        (push),
		.full        (full),
		.text_byte   (text_byte),
		.end_of_text (end_of_text),
		.empty       (empty),
		.pop         (pop),
		.out_byte    (out_byte),
		.out_last    (out_last)
	);

	// model state
	logic       mode_dec = MODE_ESCAPE;
	logic [7:0] pfx [5];
	int         pfx_n = 0;
	logic [7:0] ob [12];
	int         ob_n;

	text_item_t text_q [$];
	conv_word_t conv_q [$];
	text_item_t cur_item;
	conv_word_t got;

	int fed_n = 0;
	int acc_n = 0;
	int words_seen = 0;
	int err_n = 0;
	int n_cfg = 0;
	int n_holds = 0;
	int cyc = 0;

	// sender and receiver pacing
	int         gap_left = 0;
	int         burst_left = 0;
	int         hold_left = 0;
	int         style = 0;
	int         style_left = 0;
	logic [7:0] pop_pat = 8'hA5;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic string ent_name(input int e);
		case (e)
			0: return "&amp;";
			1: return "&lt;";
			2: return "&gt;";
			3: return "&apos;";
			default: return "&quot;";
		endcase
	endfunction

	function automatic logic [7:0] ent_char(input int e);
		case (e)
			0: return "&";
			1: return "<";
			2: return ">";
			3: return "'";
			default: return "\"";
		endcase
	endfunction

	function automatic void drain_pfx();
		int k;
		for (k = 0; k < pfx_n; k++) begin
			ob[ob_n] = pfx[k];
			ob_n++;
		end
		pfx_n = 0;
	endfunction

	// works out the words one accepted text byte turns into
	function automatic void convert_byte(input logic [7:0] c, input logic eot);
		logic [7:0] cand [6];
		string      s;
		int         len, hit, e, k;
		bit         part, same;
		conv_word_t w;
		ob_n = 0;
		if (mode_dec == MODE_ESCAPE) begin
			hit = -1;
			for (e = 0; e < NUM_ENT; e++)
				if (c == ent_char(e))
					hit = e;
			if (hit >= 0) begin
				s = ent_name(hit);
				for (k = 0; k < s.len(); k++) begin
					ob[ob_n] = s[k];
					ob_n++;
				end
			end else begin
				ob[0] = c;
				ob_n = 1;
			end
		end else begin
			for (k = 0; k < pfx_n; k++)
				cand[k] = pfx[k];
			cand[pfx_n] = c;
			len = pfx_n + 1;
			hit = -1;
			part = 1'b0;
			for (e = 0; e < NUM_ENT; e++) begin
				s = ent_name(e);
				if (len <= s.len()) begin
					same = 1'b1;
					for (k = 0; k < len; k++)
						if (cand[k] != s[k])
							same = 1'b0;
					if (same) begin
						if (len == s.len())
							hit = e;
						else
							part = 1'b1;
					end
				end
			end
			if (hit >= 0) begin
				pfx_n = 0;
				ob[0] = ent_char(hit);
				ob_n = 1;
			end else if (part) begin
				for (k = 0; k < len; k++)
					pfx[k] = cand[k];
				pfx_n = len;
			end else begin
				// failed match: held bytes go out, current byte starts over
				drain_pfx();
				if (c == CH_AMP) begin
					pfx[0] = c;
					pfx_n = 1;
				end else begin
					ob[ob_n] = c;
					ob_n++;
				end
			end
		end
		if (eot)
			drain_pfx();
		for (k = 0; k < ob_n; k++) begin
			w.data = ob[k];
			w.last = eot && (k == ob_n - 1);
			conv_q = {conv_q, w};
		end
	endfunction

	// sender: bursts of random length with random gaps
	always @(posedge clk) begin
		if (arst_n) begin
			if (push && !full) begin
				convert_byte(text_byte, end_of_text);
				acc_n++;
			end
			if (!push || !full) begin
				if (gap_left > 0) begin
					gap_left--;
					push <= 1'b0;
				end else if (text_q.size() > 0) begin
					cur_item = text_q.pop_front();
					text_byte <= cur_item.ch;
					end_of_text <= cur_item.eot;
					push <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
					end
				end else begin
					push <= 1'b0;
				end
			end
		end
	end

	// receiver: checks each popped word, stalls on its own pattern
	always @(posedge clk) begin
		if (arst_n) begin
			if (pop && !empty) begin
				if (conv_q.size() == 0) begin
					$error("unexpected word: out_byte=%02h out_last=%b", out_byte, out_last);
					err_n++;
				end else begin
					got = conv_q.pop_front();
					if (out_byte !== got.data) begin
						$error("out_byte mismatch: expected %02h, got %02h", got.data, out_byte);
						err_n++;
					end
					if (out_last !== got.last) begin
						$error("out_last mismatch: expected %b, got %b", got.last, out_last);
						err_n++;
					end
				end
				words_seen++;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else if (push && n_holds < 4 && ($urandom_range(0, 299) == 0 ||
					(n_holds == 0 && words_seen >= 100))) begin
				// long hold-off while the sender keeps pushing, fills the block up
				hold_left = $urandom_range(60, 150);
				n_holds++;
				pop <= 1'b0;
			end else begin
				if (style_left == 0) begin
					style = $urandom_range(0, 3);
					style_left = $urandom_range(16, 96);
					pop_pat = 8'($urandom_range(1, 255));
				end else begin
					style_left--;
				end
				pop_pat = {pop_pat[6:0], pop_pat[7]};
				case (style)
					0: pop <= 1'b1;
					1: pop <= pop_pat[0];
					2: pop <= ($urandom_range(0, 3) == 0);
					default: pop <= ($urandom_range(0, 9) != 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin
		cyc++;
		if (cyc > CYCLE_LIMIT) begin
			$error("timeout: %0d of %0d bytes accepted, %0d words outstanding",
				acc_n, fed_n, conv_q.size());
			$display("FAILURE");
			$finish;
		end
	end

	function automatic logic rnd_eot(input int odds);
		return $urandom_range(0, odds - 1) == 0;
	endfunction

	task automatic add_item(input logic [7:0] ch, input logic eot);
		text_item_t t;
		t.ch = ch;
		t.eot = eot;
		text_q = {text_q, t};
		fed_n++;
	endtask

	task automatic add_text(input string s, input logic eot_at_end);
		int k;
		for (k = 0; k < s.len(); k++)
			add_item(s[k], eot_at_end && (k == s.len() - 1));
	endtask

	// wait until every byte is in and every word is out, then let the pipe drain
	task automatic settle(input int extra);
		while (acc_n != fed_n || conv_q.size() != 0)
			@(posedge clk);
		repeat (extra) @(posedge clk);
	endtask

	task automatic write_mode(input logic m);
		@(posedge clk);
		cfg_valid <= 1'b1;
		decode_mode <= m;
		do
			@(posedge clk);
		while (!cfg_ready);
		mode_dec = m;
		pfx_n = 0;
		n_cfg++;
		cfg_valid <= 1'b0;
	endtask

	task automatic gen_escape(input int count);
		int i;
		for (i = 0; i < count; i++) begin
			if ($urandom_range(0, 99) < 40)
				add_item(ent_char($urandom_range(0, NUM_ENT - 1)), rnd_eot(10));
			else
				add_item(8'($urandom_range(0, 255)), rnd_eot(10));
		end
	endtask

	// mostly real entities, whole or cut short, mixed with look-alikes and noise
	task automatic gen_decode(input int count);
		string s;
		int    stop, r, cut, k;
		stop = fed_n + count;
		while (fed_n < stop) begin
			r = $urandom_range(0, 99);
			if (r < 60) begin
				s = ent_name($urandom_range(0, NUM_ENT - 1));
				cut = (r < 45) ? s.len() : $urandom_range(1, s.len() - 1);
				for (k = 0; k < cut; k++)
					add_item(s[k], rnd_eot(20));
			end else if (r < 65) begin
				add_item(CH_AMP, rnd_eot(20));
				add_item(CH_HASH, rnd_eot(20));
				cut = $urandom_range(1, 3);
				for (k = 0; k < cut; k++)
					add_item(8'("0" + $urandom_range(0, 9)), rnd_eot(20));
				add_item(CH_SEMI, rnd_eot(20));
			end else if (r < 70) begin
				add_item(CH_AMP, rnd_eot(20));
				cut = $urandom_range(1, 4);
				for (k = 0; k < cut; k++)
					add_item(8'("a" + $urandom_range(0, 25)), rnd_eot(20));
				if ($urandom_range(0, 1))
					add_item(CH_SEMI, rnd_eot(20));
			end else if (r < 90) begin
				add_item(8'($urandom_range(0, 255)), rnd_eot(20));
			end else begin
				add_item(CH_AMP, rnd_eot(20));
			end
		end
	endtask

	initial begin
		int p;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		write_mode(MODE_ESCAPE);
		add_item(8'h00, 1'b0);
		add_item(8'hFF, 1'b0);
		add_text("&<>'\"", 1'b1);
		settle(12);

		// double-encoded entity decodes once, cut entity flushed at end of text,
		// failed match restarting on a new ampersand, and a prefix left held
		write_mode(MODE_DECODE);
		add_text("&amp;lt;&g", 1'b1);
		add_text("&a&lt;", 1'b0);
		add_text("&ap", 1'b0);
		settle(12);

		// the first switch back to escape drops the held prefix
		for (p = 0; p < 6; p++) begin
			write_mode(p[0] ? MODE_DECODE : MODE_ESCAPE);
			if (p[0])
				gen_decode(100);
			else
				gen_escape(50);
			settle(12);
		end

		settle(20);
		$display("%0d text bytes in, %0d words out, %0d mode writes, %0d long output stalls",
			acc_n, words_seen, n_cfg, n_holds);
		if (err_n == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
